>>> src/tsm_pkg.sv
// Shared types and constants for the two-symbol Turing machine stepper.
// Used by tsm_rbuf and two_symbol_turing_machine_step; no dependencies.

package tsm_pkg;

  // Machine size.
  localparam int unsigned TAPE_CELLS = 4096;
  localparam int unsigned NUM_STATES = 64;

  localparam int unsigned HEAD_W     = $clog2(TAPE_CELLS);
  localparam int unsigned RULE_DEPTH = 2 * NUM_STATES;
  localparam int unsigned RULE_AW    = $clog2(RULE_DEPTH);

  localparam logic [HEAD_W-1:0] HEAD_RESET = HEAD_W'(TAPE_CELLS / 2 - 1);
  localparam logic [HEAD_W-1:0] TAPE_LAST  = HEAD_W'(TAPE_CELLS - 1);

  // Field widths fixed by the stream payload.
  localparam int unsigned STATE_W = 6;
  localparam int unsigned HPOS_W  = 12;
  localparam int unsigned STEPS_W = 32;

  // Head move codes of a rule; every other code halts the machine.
  localparam logic [1:0] MOVE_LEFT  = 2'd0;
  localparam logic [1:0] MOVE_RIGHT = 2'd1;
  localparam logic [1:0] MOVE_HALT  = 2'd2;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_STEPPED = 2'd0,
    ST_HALTED  = 2'd1,
    ST_EDGE    = 2'd2,
    ST_LOADED  = 2'd3
  } status_e;

  typedef struct packed {
    logic               wr_sym;
    logic [1:0]         move;
    logic [STATE_W-1:0] next;
  } rule_t;

  typedef struct packed {
    status_e            status;
    logic [STATE_W-1:0] state;
    logic [HPOS_W-1:0]  head;
    logic               sym;
    logic [STEPS_W-1:0] steps;
  } res_t;

endpackage

>>> src/tsm_ram.sv
// Generic single-clock RAM: one write port and one registered read port.
// No dependencies; the read data is registered.

module tsm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tsm_rbuf.sv
// Two-entry result buffer between the step logic and the output stream.
// Depends on tsm_pkg for the result type.

module tsm_rbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsm_pkg::res_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          ready_i,
  output tsm_pkg::res_t data_o
);

  tsm_pkg::res_t ent_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = ent_q[rd_ptr_q];
  assign cnt_d   = cnt_q + 2'(push_i) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> src/two_symbol_turing_machine_step.sv
// Two-symbol Turing machine stepper with the tape and rule table in RAM.
// A load item is taken every cycle while no step is in flight and the result buffer has room.
// A step item goes through the rule read, then the tape read of the new head cell.
// Its result goes through s1_valid_q, then the result buffer; no item is taken mid-step.
// Reset clears the machine registers; tape cells outside the span written so far read
// as zero, so no clearing pass is needed. Depends on tsm_pkg, tsm_ram and tsm_rbuf.

module two_symbol_turing_machine_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // rule_state[5:0], rule_symbol[6], rule_write[7], rule_move[9:8], rule_next[15:10]
  input  logic [15:0] s_axis_tdata_i,
  // operation[0]
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // machine_state[5:0], head_position[17:6], symbol_read[18], step_count[50:19], zeros above
  output logic [55:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]  m_axis_tuser_o
);

  localparam int unsigned HW = tsm_pkg::HEAD_W;
  localparam int unsigned SW = tsm_pkg::STATE_W;

  // Input fields.
  tsm_pkg::op_e    in_op;
  logic [SW-1:0]   in_rstate;
  logic            in_rsym;
  tsm_pkg::rule_t  in_rule;

  assign in_op          = tsm_pkg::op_e'(s_axis_tuser_i);
  assign in_rstate      = s_axis_tdata_i[5:0];
  assign in_rsym        = s_axis_tdata_i[6];
  assign in_rule.wr_sym = s_axis_tdata_i[7];
  assign in_rule.move   = s_axis_tdata_i[9:8];
  assign in_rule.next   = s_axis_tdata_i[15:10];

  // Machine registers.
  logic [SW-1:0]                   state_q, state_d;
  logic [HW-1:0]                   head_q, head_d;
  logic [tsm_pkg::STEPS_W-1:0]     steps_q, steps_d;
  logic                            halted_q, halted_d;
  logic                            edge_q, edge_d;
  // Span of tape cells written so far; the head never jumps, so it stays contiguous.
  logic                            wr_any_q, wr_any_d;
  logic [HW-1:0]                   lo_q, lo_d, hi_q, hi_d;

  // Step in flight between rule read and write-back.
  logic                            s1_valid_q;
  logic                            s1_sym_q;

  logic                            accept, load_acc, step_acc;
  logic                            buf_full;
  logic                            tape_rdata, sym_cur, in_span;
  logic                            tape_we;
  logic [$bits(tsm_pkg::rule_t)-1:0] rule_rdata;
  tsm_pkg::rule_t                  rule_rd;
  logic                            state_ok;
  logic [1:0]                      mv_code;
  tsm_pkg::status_e                step_status;
  tsm_pkg::res_t                   step_res, load_res, push_data, out_res;
  logic                            push;

  assign s_axis_tready_o = !s1_valid_q && !buf_full;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign load_acc = accept && (in_op == tsm_pkg::OP_LOAD);
  assign step_acc = accept && (in_op == tsm_pkg::OP_STEP);

  // The tape RAM always reads the cell under the head, so its data is the current symbol.
  assign in_span = wr_any_q && (head_q >= lo_q) && (head_q <= hi_q);
  assign sym_cur = in_span ? tape_rdata : 1'b0;

  tsm_ram #(
    .WIDTH (1),
    .DEPTH (tsm_pkg::TAPE_CELLS)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (head_q),
    .wdata_i (rule_rd.wr_sym),
    .raddr_i (head_d),
    .rdata_o (tape_rdata)
  );

  tsm_ram #(
    .WIDTH ($bits(tsm_pkg::rule_t)),
    .DEPTH (tsm_pkg::RULE_DEPTH)
  ) u_rules (
    .clk_i   (clk_i),
    .we_i    (load_acc && (32'(in_rstate) < tsm_pkg::NUM_STATES)),
    .waddr_i (tsm_pkg::RULE_AW'({in_rstate, in_rsym})),
    .wdata_i (in_rule),
    .raddr_i (tsm_pkg::RULE_AW'({state_q, sym_cur})),
    .rdata_o (rule_rdata)
  );

  assign rule_rd  = tsm_pkg::rule_t'(rule_rdata);
  assign state_ok = (32'(state_q) < tsm_pkg::NUM_STATES);
  assign mv_code  = state_ok ? rule_rd.move : tsm_pkg::MOVE_HALT;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    steps_d     = steps_q;
    halted_d    = halted_q;
    edge_d      = edge_q;
    wr_any_d    = wr_any_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tape_we     = 1'b0;
    step_status = tsm_pkg::ST_STEPPED;
    if (s1_valid_q) begin
      if (edge_q) begin
        step_status = tsm_pkg::ST_EDGE;
      end else if (halted_q) begin
        step_status = tsm_pkg::ST_HALTED;
      end else if (mv_code != tsm_pkg::MOVE_LEFT && mv_code != tsm_pkg::MOVE_RIGHT) begin
        halted_d    = 1'b1;
        step_status = tsm_pkg::ST_HALTED;
      end else begin
        tape_we  = 1'b1;
        wr_any_d = 1'b1;
        if (!wr_any_q || head_q < lo_q) begin
          lo_d = head_q;
        end
        if (!wr_any_q || head_q > hi_q) begin
          hi_d = head_q;
        end
        head_d  = (mv_code == tsm_pkg::MOVE_LEFT) ? head_q - 1'b1 : head_q + 1'b1;
        state_d = rule_rd.next;
        if (steps_q != '1) begin
          steps_d = steps_q + 1'b1;
        end
        if (head_d == '0 || head_d == tsm_pkg::TAPE_LAST) begin
          edge_d      = 1'b1;
          step_status = tsm_pkg::ST_EDGE;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_acc) begin
      s1_sym_q <= sym_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '0;
      head_q     <= tsm_pkg::HEAD_RESET;
      steps_q    <= '0;
      halted_q   <= 1'b0;
      edge_q     <= 1'b0;
      wr_any_q   <= 1'b0;
      lo_q       <= '0;
      hi_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      steps_q    <= steps_d;
      halted_q   <= halted_d;
      edge_q     <= edge_d;
      wr_any_q   <= wr_any_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      s1_valid_q <= step_acc;
    end
  end

  // Results.
  assign step_res.status = step_status;
  assign step_res.state  = state_d;
  assign step_res.head   = tsm_pkg::HPOS_W'(head_d);
  assign step_res.sym    = s1_sym_q;
  assign step_res.steps  = steps_d;

  assign load_res.status = tsm_pkg::ST_LOADED;
  assign load_res.state  = state_q;
  assign load_res.head   = tsm_pkg::HPOS_W'(head_q);
  assign load_res.sym    = sym_cur;
  assign load_res.steps  = steps_q;

  // A load is never accepted while a step is in flight, so the two never collide.
  assign push      = load_acc || s1_valid_q;
  assign push_data = s1_valid_q ? step_res : load_res;

  tsm_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tuser_o = out_res.status;
  assign m_axis_tdata_o = {5'b0, out_res.steps, out_res.sym, out_res.head, out_res.state};

`ifndef SYNTHESIS
  a_edge_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_q |=> edge_q)
    else $error("edge flag cleared without reset");

  a_steps_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> steps_q >= $past(steps_q))
    else $error("step count decreased");

  a_head_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !edge_q |-> (head_q != '0 && head_q != tsm_pkg::TAPE_LAST))
    else $error("head at tape end without edge flag");

  a_one_step_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> !s1_valid_q)
    else $error("step accepted while another was in flight");
`endif

endmodule

>>> tb/sv/tb_two_symbol_turing_machine_step.sv
// Self-checking testbench for two_symbol_turing_machine_step: streams rule loads and steps,
// predicts each result with a cycle-free machine model and checks the output stream.
// Depends on tsm_pkg and the two_symbol_turing_machine_step RTL.

module tb_two_symbol_turing_machine_step;
  timeunit 1ns;
  timeprecision 1ps;

  // Input payload, last field in the lowest bits as on s_axis_tdata_i.
  typedef struct packed {
    logic [tsm_pkg::STATE_W-1:0] nx;
    logic [1:0]                  mv;
    logic                        wr;
    logic                        sym;
    logic [tsm_pkg::STATE_W-1:0] st;
  } rule_fields_t;

  typedef struct {
    tsm_pkg::op_e op;
    rule_fields_t f;
    int unsigned  gap;
    bit           drain;
  } item_t;

  // Whole machine: tape, rule table with a written mask, and the registers.
  typedef struct packed {
    logic [tsm_pkg::TAPE_CELLS-1:0]           tape;
    tsm_pkg::rule_t [tsm_pkg::RULE_DEPTH-1:0] rules;
    logic [tsm_pkg::RULE_DEPTH-1:0]           loaded;
    logic [tsm_pkg::HEAD_W-1:0]               head;
    logic [tsm_pkg::STATE_W-1:0]              state;
    logic                                     halted;
    logic                                     at_edge;
    logic [tsm_pkg::STEPS_W-1:0]              steps;
  } machine_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  machine_t          plan_tm;
  machine_t          mirror_tm;
  item_t             cmd_q[$];
  tsm_pkg::res_t     pending_results[$];
  item_t             cur_item;
  bit                offering;
  bit                burst;
  bit                drain_next;
  int unsigned       wait_cnt;
  int unsigned       hold_cnt;
  int unsigned       results_seen;
  int unsigned       mismatches;

  two_symbol_turing_machine_step uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  // Applies one item to a machine and returns the result it must produce.
  function automatic tsm_pkg::res_t machine_advance(inout machine_t m,
                                                    input tsm_pkg::op_e op,
                                                    input rule_fields_t f);
    tsm_pkg::res_t               r;
    tsm_pkg::rule_t              ru;
    tsm_pkg::status_e            stat;
    logic                        rd;
    logic [tsm_pkg::RULE_AW-1:0] idx;
    rd = m.tape[m.head];
    if (op == tsm_pkg::OP_LOAD) begin
      if (f.st < tsm_pkg::NUM_STATES) begin
        ru.wr_sym = f.wr;
        ru.move   = f.mv;
        ru.next   = f.nx;
        idx = {f.st, f.sym};
        m.rules[idx]  = ru;
        m.loaded[idx] = 1'b1;
      end
      stat = tsm_pkg::ST_LOADED;
    end else if (m.at_edge) begin
      stat = tsm_pkg::ST_EDGE;
    end else if (m.halted) begin
      stat = tsm_pkg::ST_HALTED;
    end else begin
      idx = {m.state, rd};
      ru = m.rules[idx];
      if (m.state >= tsm_pkg::NUM_STATES) ru.move = tsm_pkg::MOVE_HALT;
      if (ru.move != tsm_pkg::MOVE_LEFT && ru.move != tsm_pkg::MOVE_RIGHT) begin
        m.halted = 1'b1;
        stat = tsm_pkg::ST_HALTED;
      end else begin
        m.tape[m.head] = ru.wr_sym;
        if (ru.move == tsm_pkg::MOVE_LEFT) begin
          if (m.head != '0) m.head = m.head - 1'b1;
        end else if (m.head != tsm_pkg::TAPE_LAST) begin
          m.head = m.head + 1'b1;
        end
        m.state = ru.next;
        if (m.steps != '1) m.steps = m.steps + 1'b1;
        if (m.head == '0 || m.head == tsm_pkg::TAPE_LAST) begin
          m.at_edge = 1'b1;
          stat = tsm_pkg::ST_EDGE;
        end else begin
          stat = tsm_pkg::ST_STEPPED;
        end
      end
    end
    r.status = stat;
    r.state  = m.state;
    r.head   = m.head;
    r.sym    = rd;
    r.steps  = m.steps;
    return r;
  endfunction

  function automatic void push_cmd(input tsm_pkg::op_e op, input rule_fields_t f);
    item_t it;
    it.op    = op;
    it.f     = f;
    it.gap   = burst ? 0 : $urandom_range(0, 4);
    it.drain = drain_next;
    drain_next = 1'b0;
    void'(machine_advance(plan_tm, op, f));
    cmd_q.push_back(it);
  endfunction

  function automatic void push_load(input logic [tsm_pkg::STATE_W-1:0] st, input logic sym,
                                    input logic wr, input logic [1:0] mv,
                                    input logic [tsm_pkg::STATE_W-1:0] nx);
    rule_fields_t f;
    f.st  = st;
    f.sym = sym;
    f.wr  = wr;
    f.mv  = mv;
    f.nx  = nx;
    push_cmd(tsm_pkg::OP_LOAD, f);
  endfunction

  function automatic void push_random_load();
    push_cmd(tsm_pkg::OP_LOAD, rule_fields_t'($urandom));
  endfunction

  // A running machine must never look up a rule that was not written, and only the
  // planned ending may halt it, so a missing or halting rule is replaced first.
  function automatic void push_step();
    logic                        rd;
    logic [tsm_pkg::RULE_AW-1:0] idx;
    rd  = plan_tm.tape[plan_tm.head];
    idx = {plan_tm.state, rd};
    if (!plan_tm.halted && !plan_tm.at_edge &&
        (!plan_tm.loaded[idx] || plan_tm.rules[idx].move > tsm_pkg::MOVE_RIGHT))
      push_load(plan_tm.state, rd, 1'($urandom), 2'($urandom_range(0, 1)),
                tsm_pkg::STATE_W'($urandom));
    push_cmd(tsm_pkg::OP_STEP, rule_fields_t'($urandom));
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function automatic void check_result(input logic [1:0] st_bits, input logic [55:0] d);
    tsm_pkg::res_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $error("result with status %0d arrived with no item outstanding", st_bits);
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", want.status, st_bits);
    compare_field("machine_state", want.state, d[5:0]);
    compare_field("head_position", want.head, d[17:6]);
    compare_field("symbol_read", want.sym, d[18]);
    compare_field("step_count", want.steps, d[50:19]);
  endfunction

  // Sender: offers queued items after their gap; a drain item waits for all results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
      wait_cnt = 0;
    end else begin
      offering = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_results.push_back(machine_advance(mirror_tm, cur_item.op, cur_item.f));
        offering = 1'b0;
      end
      if (!offering && cmd_q.size() != 0 &&
          !(cmd_q[0].drain && pending_results.size() != 0)) begin
        if (wait_cnt < cmd_q[0].gap) begin
          wait_cnt++;
        end else begin
          cur_item = cmd_q.pop_front();
          wait_cnt = 0;
          offering = 1'b1;
          s_axis_tdata_i <= cur_item.f;
          s_axis_tuser_i <= cur_item.op;
        end
      end
      s_axis_tvalid_i <= offering;
    end
  end

  // Receiver: random stall after each item, one long hold-off, one stretch with none.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt = 0;
      results_seen = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_result(m_axis_tuser_o, m_axis_tdata_o);
        results_seen++;
        if (results_seen == 250) hold_cnt = 120;
        else if (results_seen >= 500 && results_seen < 650) hold_cnt = 0;
        else hold_cnt = $urandom_range(0, 4);
      end else if (hold_cnt != 0) begin
        hold_cnt--;
      end
      m_axis_tready_i <= (hold_cnt == 0);
    end
  end

  initial begin
    int unsigned ending;
    plan_tm      = '0;
    plan_tm.head = tsm_pkg::HEAD_RESET;
    mirror_tm    = plan_tm;
    mismatches   = 0;
    burst        = 1'b0;
    drain_next   = 1'b0;

    // Directed opening: extreme fields, both moves, both symbols read, halt codes loaded.
    push_load('1, 1'b1, 1'b1, 2'd3, '1);
    push_load('0, 1'b0, 1'b1, tsm_pkg::MOVE_RIGHT, '1);
    push_step();
    push_load('1, 1'b0, 1'b1, tsm_pkg::MOVE_LEFT, '0);
    push_step();
    push_load('0, 1'b1, 1'b0, tsm_pkg::MOVE_LEFT, 6'd21);
    push_step();
    push_load('0, 1'b0, 1'b0, tsm_pkg::MOVE_LEFT, '0);
    push_load(6'd21, 1'b0, 1'b1, tsm_pkg::MOVE_RIGHT, 6'd42);
    push_load(6'd42, 1'b1, 1'b0, tsm_pkg::MOVE_HALT, 6'd5);
    push_step();
    push_step();
    push_step();
    push_load(6'd42, 1'b0, 1'b1, tsm_pkg::MOVE_LEFT, 6'd63);
    push_step();
    push_step();

    drain_next = 1'b1;
    for (int i = 0; i < 1150; i++) begin
      burst = (i >= 250 && i < 360) || (i >= 800 && i < 870);
      if (i == 575) drain_next = 1'b1;
      if ($urandom_range(0, 99) < 30) push_random_load();
      else push_step();
    end
    burst = 1'b0;

    // Only one way of stopping is possible per run, so the halting move code is drawn.
    ending = $urandom_range(0, 1);
    push_load(plan_tm.state, plan_tm.tape[plan_tm.head], 1'($urandom),
              (ending == 0) ? tsm_pkg::MOVE_HALT : 2'd3, tsm_pkg::STATE_W'($urandom));
    push_cmd(tsm_pkg::OP_STEP, rule_fields_t'($urandom));

    // The machine is stopped now: steps only report, loads still go in.
    push_step();
    push_random_load();
    push_step();
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 1) != 0) push_step();
      else push_random_load();
    end

    while (cmd_q.size() != 0 || offering || s_axis_tvalid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
